### sv/spq_pkg.sv
// Shared types, sizes and status codes of the sorted priority queue.
package spq_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned PrioW = 16;
  localparam int unsigned ItemW = 32;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0]        prio;
    logic signed [ItemW-1:0] item;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [PrioW-1:0] prio;
    logic [ItemW-1:0] item;
  } cell_op_t;

endpackage

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: cell chain, fill count and output skid stage.
//
// The queue holds up to eight entries in a chain of cells kept in ascending priority
// order; equal priorities leave in arrival order. Every cell compares its own priority
// with an incoming one at the same time, so the block takes one insert or remove a
// cycle while not stalled and registers its result. A two-register output stage lets
// the block keep taking transfers while one result waits; it stalls only when both
// are occupied. An insert into a full queue is dropped and reports full, a remove from
// an empty queue reports empty, and both then return zero priority and item.
module sorted_priority_queue_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [spq_pkg::PrioW-1:0]          priority_req_i,
  input  logic signed [spq_pkg::ItemW-1:0]   item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic [spq_pkg::PrioW-1:0]          out_priority_o,
  output logic signed [spq_pkg::ItemW-1:0]   out_item_o
);
  import spq_pkg::*;

  typedef struct packed {
    status_e                 status;
    logic [PrioW-1:0]        prio;
    logic signed [ItemW-1:0] item;
  } result_t;

  logic [CntW-1:0] fill_cnt_q, fill_cnt_d;
  logic            in_acc, out_fire, is_full, is_empty, is_ins;
  logic [Depth-1:0] occupied, disp;
  entry_t          cell_entry [Depth];
  cell_op_t        op;
  result_t         res, out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  assign in_acc   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;
  assign is_ins   = (kind_i == KindInsert);
  assign is_full  = (fill_cnt_q == CntW'(Depth));
  assign is_empty = (fill_cnt_q == '0);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      occupied[i] = (CntW'(i) < fill_cnt_q);
    end
  end

  always_comb begin
    op.ins  = in_acc && is_ins && !is_full;
    op.rem  = in_acc && !is_ins && !is_empty;
    op.prio = priority_req_i;
    op.item = item_i;
  end

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .occupied_i   (occupied[g]),
      .prev_disp_i  ((g == 0) ? 1'b0 : disp[(g == 0) ? 0 : g - 1]),
      .prev_entry_i (cell_entry[(g == 0) ? 0 : g - 1]),
      .next_entry_i (cell_entry[(g == Depth - 1) ? g : g + 1]),
      .disp_o       (disp[g]),
      .entry_o      (cell_entry[g])
    );
  end

  always_comb begin
    fill_cnt_d = fill_cnt_q;
    if (op.ins) begin
      fill_cnt_d = fill_cnt_q + CntW'(1);
    end else if (op.rem) begin
      fill_cnt_d = fill_cnt_q - CntW'(1);
    end
  end

  always_comb begin
    res.prio = '0;
    res.item = '0;
    if (is_ins) begin
      res.status = is_full ? StFull : StDone;
    end else if (is_empty) begin
      res.status = StEmpty;
    end else begin
      res.status = StDone;
      res.prio   = cell_entry[0].prio;
      res.item   = cell_entry[0].item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      fill_cnt_q <= fill_cnt_d;
      if (out_fire || !out_valid_q) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else if (in_acc) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b0;
        end
      end else if (in_acc) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign out_priority_o = out_q.prio;
  assign out_item_o     = out_q.item;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_cnt_q <= CntW'(Depth))
    else $error("Fill count exceeds the queue depth.");

  a_skid_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid register holds a result while the output register is empty.");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_ins && is_full) |=> (fill_cnt_q == $past(fill_cnt_q)))
    else $error("A dropped insert changed the fill count.");

  a_remove_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_ins && !is_empty) |=> (fill_cnt_q == $past(fill_cnt_q) - CntW'(1)))
    else $error("A remove did not lower the fill count.");

endmodule

### sv/spq_cell.sv
// One cell of the sorted chain: holds one entry and shifts it toward its neighbors.
module spq_cell (
  input  logic            clk_i,
  input  spq_pkg::cell_op_t op_i,
  input  logic            occupied_i,
  input  logic            prev_disp_i,
  input  spq_pkg::entry_t prev_entry_i,
  input  spq_pkg::entry_t next_entry_i,
  output logic            disp_o,
  output spq_pkg::entry_t entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // A cell is displaced by an insert when it is empty or holds a strictly larger priority.
  assign disp_o = !occupied_i || (entry_q.prio > op_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins && disp_o) begin
      if (prev_disp_i) begin
        entry_d = prev_entry_i;
      end else begin
        entry_d.prio = op_i.prio;
        entry_d.item = op_i.item;
      end
    end else if (op_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
